// ===== hw/rtl/lpsc_pkg.sv =====
package lpsc_pkg;

   // configuration register indexes
   localparam logic REG_LENGTH_FIELD_BYTES = 1'b0;
   localparam logic REG_OUTPUT_CAPACITY    = 1'b1;

   // reset values of the configuration registers
   localparam logic [2:0]  LENGTH_FIELD_BYTES_RESET = 3'd4;
   localparam logic [31:0] OUTPUT_CAPACITY_RESET    = 32'hFFFF_FFFF;

   // largest total that still gives a success status
   localparam logic [31:0] COUNT_LIMIT = 32'h7FFF_FFFF;

   // bytes of the start code 00 00 00 01 and the index of its last beat
   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [7:0] START_CODE_LAST = 8'h01;
   localparam logic [1:0] START_CODE_LAST_BEAT = 2'd3;

   // input beat kinds
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // output beat kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // queued result records
   localparam logic [1:0] REC_BYTE   = 2'd0;
   localparam logic [1:0] REC_START  = 2'd1;
   localparam logic [1:0] REC_STATUS = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        error;
      logic [31:0] total;
   } rec_type;

endpackage

// ===== hw/rtl/length_prefix_to_start_code_core.sv =====
// Converts a buffer of length-prefixed video units, taken one byte per beat, into
// start-code framing. Each unit's big-endian length field (1, 2 or 4 bytes, set by
// the length_field_bytes register) is replaced by the four bytes 00 00 00 01 and the
// body is passed through. An end-of-buffer beat (req_tuser = 1) yields one status
// beat (rsp_tuser = 1) carrying the error flag and the output byte count, then the
// block is ready for the next buffer. Each length byte and body byte is one input
// beat; a completed length field yields a four-beat start-code burst from a single
// queued record. Results go through a two-record queue, so input is taken while a
// result still waits on the output. After an error, data bytes are swallowed until
// the end beat; the caller drops the partial output. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module length_prefix_to_start_code_core
   import lpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] req_type
   // output stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [8] status_error,
                                    // [40:9] total_bytes, [47:41] zero
   output logic        rsp_tuser,   // [0] item_kind
   output logic        rsp_tlast,   // run_last
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [2:0]  lfb_ff;
   logic [31:0] cap_ff;

   // buffer parse state
   logic        in_body_ff, in_body_in;
   logic        sticky_ff, sticky_in;
   logic [2:0]  seen_ff, seen_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] count_ff, count_in;

   // result queue
   rec_type     rec_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  qcnt_ff, qcnt_in;
   logic [1:0]  sub_ff;

   logic        req_fire;
   logic        push;
   rec_type     push_rec;
   rec_type     head;
   logic        head_last;
   logic        pop;
   logic        size_ok;
   logic [2:0]  seen_next;
   logic [31:0] acc_next;
   logic [33:0] need;

   assign size_ok  = (lfb_ff == 3'd1) || (lfb_ff == 3'd2) || (lfb_ff == 3'd4);
   assign req_tready = (qcnt_ff != 2'd2);
   assign req_fire = req_tvalid && req_tready;

   // length field accumulation and capacity check
   assign seen_next = seen_ff + 3'd1;
   assign acc_next  = {acc_ff[23:0], req_tdata};
   assign need      = {2'b00, count_ff} + {2'b00, acc_next} + 34'd4;

   // parse step for one accepted beat
   always_comb begin
      in_body_in = in_body_ff;
      sticky_in  = sticky_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_rec   = '0;
      if (req_fire) begin
         if (req_tuser == REQ_END) begin
            push           = 1'b1;
            push_rec.kind  = REC_STATUS;
            push_rec.error = sticky_ff || !size_ok || in_body_ff || (seen_ff != 3'd0)
                             || (count_ff > COUNT_LIMIT);
            push_rec.total = count_ff;
            in_body_in = 1'b0;
            sticky_in  = 1'b0;
            seen_in    = 3'd0;
            acc_in     = '0;
            left_in    = '0;
            count_in   = '0;
         end else if (!size_ok) begin
            sticky_in = 1'b1;
         end else if (sticky_ff) begin
            // swallowed after an error
         end else if (in_body_ff) begin
            push          = 1'b1;
            push_rec.kind = REC_BYTE;
            push_rec.data = req_tdata;
            count_in      = count_ff + 32'd1;
            left_in       = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               in_body_in = 1'b0;
            end
         end else if (seen_next >= lfb_ff) begin
            seen_in = 3'd0;
            acc_in  = '0;
            if ((acc_next == 32'd0) || (need > {2'b00, cap_ff})) begin
               sticky_in = 1'b1;
            end else begin
               push          = 1'b1;
               push_rec.kind = REC_START;
               count_in      = count_ff + 32'd4;
               left_in       = acc_next;
               in_body_in    = 1'b1;
            end
         end else begin
            seen_in = seen_next;
            acc_in  = acc_next;
         end
      end
   end

   // head of the queue drives the output beat
   assign head       = rec_ff[rd_ptr_ff];
   assign head_last  = (head.kind != REC_START) || (sub_ff == START_CODE_LAST_BEAT);
   assign rsp_tvalid = (qcnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready && head_last;
   assign rsp_tlast  = head_last;
   assign rsp_tuser  = (head.kind == REC_STATUS) ? KIND_STATUS : KIND_BYTE;

   always_comb begin
      rsp_tdata = '0;
      case (head.kind)
         REC_START: begin
            rsp_tdata[7:0] = (sub_ff == START_CODE_LAST_BEAT) ? START_CODE_LAST
                                                              : START_CODE_ZERO;
         end
         REC_STATUS: begin
            rsp_tdata[8]    = head.error;
            rsp_tdata[40:9] = head.total;
         end
         default: begin
            rsp_tdata[7:0] = head.data;
         end
      endcase
   end

   always_comb begin
      qcnt_in = qcnt_ff;
      if (push && !pop) begin
         qcnt_in = qcnt_ff + 2'd1;
      end else if (pop && !push) begin
         qcnt_in = qcnt_ff - 2'd1;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lfb_ff     <= LENGTH_FIELD_BYTES_RESET;
         cap_ff     <= OUTPUT_CAPACITY_RESET;
         in_body_ff <= 1'b0;
         sticky_ff  <= 1'b0;
         seen_ff    <= '0;
         acc_ff     <= '0;
         left_ff    <= '0;
         count_ff   <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         qcnt_ff    <= '0;
         sub_ff     <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_LENGTH_FIELD_BYTES) begin
               lfb_ff <= csr_wdata[2:0];
            end else begin
               cap_ff <= csr_wdata;
            end
         end
         in_body_ff <= in_body_in;
         sticky_ff  <= sticky_in;
         seen_ff    <= seen_in;
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         count_ff   <= count_in;
         qcnt_ff    <= qcnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sub_ff    <= '0;
         end else if (rsp_tvalid && rsp_tready) begin
            sub_ff <= sub_ff + 2'd1;
         end
      end
   end

   // a start-code burst in progress sits at the head of the queue
   a_sub_start : assert property (@(posedge clock) disable iff (reset)
      (sub_ff != 2'd0) |-> (rsp_tvalid && (head.kind == REC_START)))
      else $error("start code beat counter runs without a start record");

   // an end beat returns the parse state to idle
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == REQ_END)) |=>
         (!in_body_ff && !sticky_ff && (seen_ff == 3'd0) && (count_ff == 32'd0)))
      else $error("parse state not cleared after end of buffer");

   // a body in progress always has bytes left and no partial field
   a_body_left : assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> ((left_ff != 32'd0) && (seen_ff == 3'd0)))
      else $error("body state without remaining bytes");

   // the queue never holds more than two records
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      (qcnt_ff != 2'd3) && !(push && (qcnt_ff == 2'd2)))
      else $error("result queue overflow");

endmodule

// ===== tb/tb_length_prefix_to_start_code_core.sv =====
module tb_length_prefix_to_start_code_core;
   import lpsc_pkg::*;

   // one expected output beat
   typedef struct {
      logic        kind;
      logic [7:0]  data;
      logic        error;
      logic [31:0] total;
      logic        last;
   } framed_beat_type;

   // tracks the conversion state and holds the output beats still due
   class start_code_scoreboard_type;
      logic [2:0]      prefix_size;
      logic [31:0]     capacity;
      bit              in_body;
      bit              sticky_error;
      bit [2:0]        prefix_seen;
      bit [31:0]       length_accum;
      bit [31:0]       body_left;
      bit [31:0]       out_count;
      framed_beat_type framed_beats_due[$];
      int unsigned     failures;

      function new();
         prefix_size = LENGTH_FIELD_BYTES_RESET;
         capacity    = OUTPUT_CAPACITY_RESET;
         failures    = 0;
         clear_buffer();
      endfunction

      function void clear_buffer();
         in_body      = 1'b0;
         sticky_error = 1'b0;
         prefix_seen  = '0;
         length_accum = '0;
         body_left    = '0;
         out_count    = '0;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         if (idx == REG_LENGTH_FIELD_BYTES) begin
            prefix_size = value[2:0];
         end else begin
            capacity = value;
         end
      endfunction

      function bit size_ok();
         return prefix_size == 3'd1 || prefix_size == 3'd2 || prefix_size == 3'd4;
      endfunction

      function void due(logic kind, logic [7:0] data, logic error, logic [31:0] total,
                        logic last);
         framed_beat_type b;
         b.kind  = kind;
         b.data  = data;
         b.error = error;
         b.total = total;
         b.last  = last;
         framed_beats_due.push_back(b);
      endfunction

      // returns 0 when the beat is swallowed without effect
      function bit predict_framing(logic req_kind, logic [7:0] data);
         bit [31:0] len;
         bit [63:0] need;
         bit        bad;
         // end of buffer: status beat, then the buffer parse state is cleared
         if (req_kind == REQ_END) begin
            bad = sticky_error || !size_ok() || in_body || prefix_seen != 0 ||
                  out_count > COUNT_LIMIT;
            due(KIND_STATUS, 8'h00, bad, out_count, 1'b1);
            clear_buffer();
            return 1'b1;
         end
         if (!size_ok()) begin
            sticky_error = 1'b1;
            return 1'b1;
         end
         if (sticky_error) return 1'b0;
         // body byte passes through
         if (in_body) begin
            due(KIND_BYTE, data, 1'b0, 32'd0, 1'b1);
            out_count++;
            body_left--;
            if (body_left == 0) in_body = 1'b0;
            return 1'b1;
         end
         // length field byte, big endian
         length_accum = {length_accum[23:0], data};
         prefix_seen  = prefix_seen + 3'd1;
         if (prefix_seen >= prefix_size) begin
            len          = length_accum;
            need         = {32'd0, out_count} + 64'd4 + {32'd0, len};
            prefix_seen  = '0;
            length_accum = '0;
            if (len == 0 || need > {32'd0, capacity}) begin
               sticky_error = 1'b1;
            end else begin
               due(KIND_BYTE, START_CODE_ZERO, 1'b0, 32'd0, 1'b0);
               due(KIND_BYTE, START_CODE_ZERO, 1'b0, 32'd0, 1'b0);
               due(KIND_BYTE, START_CODE_ZERO, 1'b0, 32'd0, 1'b0);
               due(KIND_BYTE, START_CODE_LAST, 1'b0, 32'd0, 1'b1);
               out_count += 4;
               body_left  = len;
               in_body    = 1'b1;
            end
         end
         return 1'b1;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_framed_beat(logic kind, logic [7:0] data, logic error,
                                      logic [31:0] total, logic last);
         framed_beat_type want;
         if (framed_beats_due.size() == 0) begin
            $error("output beat with nothing due: kind %0h byte %0h", kind, data);
            failures++;
            return;
         end
         want = framed_beats_due.pop_front();
         compare_field("item_kind", want.kind, kind);
         compare_field("out_byte", want.data, data);
         compare_field("status_error", want.error, error);
         compare_field("total_bytes", want.total, total);
         compare_field("run_last", want.last, last);
      endfunction
   endclass

   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   start_code_scoreboard_type sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_count = 0;
   int fed_items = 0;
   int stall_count = 0;

   length_prefix_to_start_code_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_count > 0) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // output beat checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_framed_beat(rsp_tuser, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[40:9],
                              rsp_tlast);
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("tb_length_prefix_to_start_code_core failed");
            $finish;
         end
      end
   end

   // offer one input beat and wait until it is taken
   task automatic send_beat(input logic req_kind, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req_kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (sb.predict_framing(req_kind, data)) fed_items++;
   endtask

   task automatic send_data(input logic [7:0] data);
      send_beat(REQ_DATA, data);
   endtask

   task automatic send_end();
      send_beat(REQ_END, 8'($urandom_range(255)));
   endtask

   // wait until all output has drained and the block is idle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.framed_beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // length field of the configured width (a random width of 1 to 4 bytes if invalid), then body bytes
   task automatic send_unit(input int unsigned len, input int unsigned body_n);
      int width;
      width = (sb.prefix_size inside {3'd1, 3'd2, 3'd4}) ? int'(sb.prefix_size)
                                                         : $urandom_range(4, 1);
      for (int i = width - 1; i >= 0; i--) send_data(8'(len >> (8 * i)));
      repeat (body_n) send_data(8'($urandom_range(255)));
   endtask

   // mostly well-formed buffers, some broken ones
   task automatic send_buffer(input bit long_unit);
      int unsigned len, pick;
      for (int u = $urandom_range(3, 1); u > 0; u--) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(9) == 0 || long_unit) ? $urandom_range(24, 9)
                                                      : $urandom_range(6, 1);
         if (pick < 78) begin
            send_unit(len, len);
         end else if (pick < 84) begin
            // zero length, then bytes that get swallowed
            send_unit(0, $urandom_range(2));
         end else if (pick < 90) begin
            // body cut short by the end beat
            send_unit(len, $urandom_range(len - 1));
            break;
         end else if (pick < 95) begin
            // random noise, possibly a huge length
            repeat ($urandom_range(6, 1)) send_data(8'($urandom_range(255)));
         end else begin
            // one field byte, then the end beat (cuts the field short unless it is one byte wide)
            send_data(8'($urandom_range(255)));
            break;
         end
      end
      send_end();
   endtask

   task automatic random_config();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 8) begin
         case ($urandom_range(2))
            0: write_reg(REG_LENGTH_FIELD_BYTES, 32'd1);
            1: write_reg(REG_LENGTH_FIELD_BYTES, 32'd2);
            default: write_reg(REG_LENGTH_FIELD_BYTES, 32'd4);
         endcase
      end else begin
         write_reg(REG_LENGTH_FIELD_BYTES, 32'($urandom_range(7)));
      end
      pick = $urandom_range(9);
      if (pick < 6) begin
         write_reg(REG_OUTPUT_CAPACITY, 32'hFFFF_FFFF);
      end else if (pick < 8) begin
         write_reg(REG_OUTPUT_CAPACITY, 32'($urandom_range(40, 5)));
      end else if (pick == 8) begin
         write_reg(REG_OUTPUT_CAPACITY, 32'd0);
      end else begin
         write_reg(REG_OUTPUT_CAPACITY, $urandom);
      end
   endtask

   initial begin
      sb         = new();
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_DATA;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_LENGTH_FIELD_BYTES;
      csr_wdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: reset config, unit of two bytes with extreme body values
      send_data(8'h00); send_data(8'h00); send_data(8'h00); send_data(8'h02);
      send_data(8'h00); send_data(8'hFF);
      send_beat(REQ_END, 8'hFF);
      // zero length, then a byte swallowed after the error
      send_data(8'h00); send_data(8'h00); send_data(8'h00); send_data(8'h00);
      send_data(8'hAA);
      send_beat(REQ_END, 8'h00);
      // field cut short
      send_data(8'h00); send_data(8'h01);
      send_end();

      // one-byte field, capacity exactly fits the first unit, then runs out
      settle();
      write_reg(REG_LENGTH_FIELD_BYTES, 32'd1);
      write_reg(REG_OUTPUT_CAPACITY, 32'd5);
      send_data(8'h01); send_data(8'h5A); send_data(8'h01);
      send_end();

      // invalid field size
      settle();
      write_reg(REG_LENGTH_FIELD_BYTES, 32'd3);
      send_data(8'h80);
      send_end();

      // empty buffer with zero capacity
      settle();
      write_reg(REG_LENGTH_FIELD_BYTES, 32'd2);
      write_reg(REG_OUTPUT_CAPACITY, 32'd0);
      send_end();

      // size shrinks mid-field, then capacity drops below the count
      settle();
      write_reg(REG_LENGTH_FIELD_BYTES, 32'd4);
      write_reg(REG_OUTPUT_CAPACITY, 32'hFFFF_FFFF);
      send_data(8'h00);
      settle();
      write_reg(REG_LENGTH_FIELD_BYTES, 32'd1);
      send_data(8'h01); send_data(8'h80);
      settle();
      write_reg(REG_OUTPUT_CAPACITY, 32'd2);
      send_data(8'h01);
      send_end();

      // random buffers over three idling profiles
      fed_items = 0;
      send_idle_pct = 36;
      recv_idle_pct = 88;
      while (fed_items < 150) begin
         settle();
         if (fed_items >= 50 && send_idle_pct == 36) begin
            send_idle_pct = 88;
            recv_idle_pct = 36;
         end else if (fed_items >= 100 && send_idle_pct == 88) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // long receiver hold-off so the block backs up into its input
            write_reg(REG_LENGTH_FIELD_BYTES, 32'd2);
            write_reg(REG_OUTPUT_CAPACITY, 32'hFFFF_FFFF);
            hold_count = 80;
            send_unit(24, 24);
            send_end();
            continue;
         end
         random_config();
         send_buffer(1'b0);
      end

      // drain and report
      settle();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.framed_beats_due.size() == 0) begin
         $display("tb_length_prefix_to_start_code_core passed");
      end else begin
         $display("tb_length_prefix_to_start_code_core failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lpsc_pkg.sv
hw/rtl/length_prefix_to_start_code_core.sv
tb/tb_length_prefix_to_start_code_core.sv
